// ===== rtl/bdpc_pkg.sv =====
// Shared constants, types and codes for the button debounce and press classifier.
package bdpc_pkg;

    localparam int NUM_BUTTONS     = 4;
    localparam int COUNT_WIDTH     = 16;
    localparam int LEVEL_WIDTH     = 4;
    localparam int NUM_CODE_FIELDS = 4;
    localparam int THR_WIDTH       = 16;
    localparam int CMP_WIDTH       = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
    localparam int REPORT_WIDTH    = 4;
    localparam int CFG_INDEX_WIDTH = 1;

    typedef logic [1:0]              press_code_t;
    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [THR_WIDTH-1:0]    thr_t;
    typedef logic [REPORT_WIDTH-1:0] report_t;

    localparam press_code_t CODE_NONE  = 2'd0;
    localparam press_code_t CODE_SHORT = 2'd1;
    localparam press_code_t CODE_LONG  = 2'd2;

    localparam report_t REPORT_NONE  = 4'd0;
    localparam report_t REPORT_MULTI = 4'd10;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 1'd1;

    localparam thr_t DEBOUNCE_RESET   = 16'd10;
    localparam thr_t LONG_PRESS_RESET = 16'd100;

    // Status of one button lane for the word being processed.
    typedef struct packed {
        logic        hit;
        press_code_t code_next;
    } lane_stat_t;

endpackage

// ===== rtl/bdpc_input_stage.sv =====
// Input register with stall generation for the button level words.
module bdpc_input_stage
    import bdpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [LEVEL_WIDTH-1:0] button_levels,
    input  logic                   drain,
    output logic                   full,
    output logic [LEVEL_WIDTH-1:0] levels
);

    logic                   full_reg;
    logic                   full_next;
    logic [LEVEL_WIDTH-1:0] levels_reg;
    logic                   accept;

    // The held word leaves whenever the result register can take it, so a new
    // word is taken in the same cycle.
    assign in_stall = full_reg && !drain;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (drain)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= button_levels;
        end
    end

    assign full   = full_reg;
    assign levels = levels_reg;

endmodule

// ===== rtl/bdpc_button_lane.sv =====
// Hold counter and sticky press code of one button.
module bdpc_button_lane
    import bdpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        pressed,
    input  thr_t        deb_limit,
    input  thr_t        long_limit,
    output lane_stat_t  stat
);

    count_t      count_reg;
    count_t      count_next;
    press_code_t code_reg;
    logic        reach_debounce;
    logic        reach_long;

    assign reach_debounce = CMP_WIDTH'(count_reg) >= CMP_WIDTH'(deb_limit);
    assign reach_long     = CMP_WIDTH'(count_reg) >= CMP_WIDTH'(long_limit);

    always_comb
    begin
        stat.hit       = 1'b0;
        stat.code_next = code_reg;
        count_next     = count_reg;
        if (pressed)
        begin
            // The counter saturates at all ones.
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            count_next = '0;
            if (reach_debounce)
            begin
                stat.hit       = 1'b1;
                stat.code_next = reach_long ? CODE_LONG : CODE_SHORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            code_reg  <= CODE_NONE;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            code_reg  <= stat.code_next;
        end
    end

endmodule

// ===== rtl/bdpc_result_stage.sv =====
// Event summary, reported button register and output register.
module bdpc_result_stage
    import bdpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [NUM_BUTTONS-1:0]  hits,
    input  press_code_t             codes [NUM_CODE_FIELDS],
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic                    drain,
    output logic                    irq_pulse,
    output press_code_t             code_out [NUM_CODE_FIELDS],
    output report_t                 reported_button
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        irq_reg;
    press_code_t code_reg [NUM_CODE_FIELDS];
    report_t     reported_reg;
    report_t     reported_next;
    logic        any_hit;
    logic        multi_hit;
    report_t     who;

    assign drain = !out_valid_reg || !out_stall;

    always_comb
    begin
        any_hit   = 1'b0;
        multi_hit = 1'b0;
        who       = REPORT_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (hits[i])
            begin
                multi_hit = multi_hit || any_hit;
                any_hit   = 1'b1;
                who       = REPORT_WIDTH'(i + 1);
            end
        end
    end

    always_comb
    begin
        if (!any_hit)
        begin
            reported_next = reported_reg;
        end
        else if (multi_hit)
        begin
            reported_next = REPORT_MULTI;
        end
        else
        begin
            reported_next = who;
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            reported_reg  <= REPORT_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                reported_reg <= reported_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            irq_reg <= any_hit;
            for (int j = 0; j < NUM_CODE_FIELDS; j++)
            begin
                code_reg[j] <= codes[j];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign irq_pulse       = irq_reg;
    assign code_out        = code_reg;
    assign reported_button = reported_reg;

endmodule

// ===== rtl/button_debounce_press_classifier_top.sv =====
// Top level of the button debounce and short/long press classifier.
//
// Usage: each input word is one timer tick carrying the four active-low
// button levels on button_levels. A word is taken when in_valid is high and
// in_stall is low. Every word yields exactly one result word, taken when
// out_valid is high and out_stall is low: irq_pulse, the four sticky press
// codes and reported_button.
// A taken word sits in the input register until the result register can
// take it; then the per-button count and compare logic writes the result
// register and out_valid rises.
// Throughput is one word per cycle while out_stall is low; the per-button
// compare and count path between the two registers sets that figure.
// While the receiver stalls, the result word holds, the input register keeps
// one more word and in_stall rises only once both are full.
// Reset clears the hold counters, the codes, the reported button and all
// valid flags, and loads the thresholds with 10 and 100 ticks. Thresholds are
// written through wr_en, wr_index and wr_data while no word is in flight.
module button_debounce_press_classifier_top
    import bdpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [THR_WIDTH-1:0]       wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [LEVEL_WIDTH-1:0]     button_levels,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       irq_pulse,
    output logic [1:0]                 code_button_one,
    output logic [1:0]                 code_button_two,
    output logic [1:0]                 code_button_three,
    output logic [1:0]                 code_button_four,
    output logic [REPORT_WIDTH-1:0]    reported_button
);

    thr_t                   debounce_reg;
    thr_t                   long_press_reg;
    logic                   drain;
    logic                   full;
    logic                   fire;
    logic [LEVEL_WIDTH-1:0] levels;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] hits;
    lane_stat_t             stat [NUM_BUTTONS];
    press_code_t            codes [NUM_CODE_FIELDS];
    press_code_t            code_out [NUM_CODE_FIELDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DEBOUNCE:   debounce_reg   <= wr_data;
                REG_LONG_PRESS: long_press_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    bdpc_input_stage u_input_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_levels (button_levels),
        .drain         (drain),
        .full          (full),
        .levels        (levels)
    );

    assign fire = full && drain;

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++)
        begin : g_lane
            // Buttons without an input bit always read as released.
            if (g < LEVEL_WIDTH)
            begin : g_pin
                assign pressed[g] = !levels[g];
            end
            else
            begin : g_nopin
                assign pressed[g] = 1'b0;
            end

            bdpc_button_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .fire       (fire),
                .pressed    (pressed[g]),
                .deb_limit  (debounce_reg),
                .long_limit (long_press_reg),
                .stat       (stat[g])
            );

            assign hits[g] = stat[g].hit;
        end

        for (g = 0; g < NUM_CODE_FIELDS; g++)
        begin : g_code
            if (g < NUM_BUTTONS)
            begin : g_present
                assign codes[g] = stat[g].code_next;
            end
            else
            begin : g_absent
                assign codes[g] = CODE_NONE;
            end
        end
    endgenerate

    bdpc_result_stage u_result_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .hits            (hits),
        .codes           (codes),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .drain           (drain),
        .irq_pulse       (irq_pulse),
        .code_out        (code_out),
        .reported_button (reported_button)
    );

    assign code_button_one   = code_out[0];
    assign code_button_two   = code_out[1];
    assign code_button_three = code_out[2];
    assign code_button_four  = code_out[3];

endmodule
